>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

>>> hdl/ttps_pkg.sv
// ----------------------------------------------------------------------------
// ttps_pkg
// Types, constants and helpers for the transposition table probe/store block.
// ----------------------------------------------------------------------------
package ttps_pkg;

	// table geometry; ENTRIES is a power of two so the slot is the low key bits
	localparam int ENTRIES = 4096;
	localparam int IDX_W   = $clog2(ENTRIES);

	localparam int MATE_VALUE = 30000;
	localparam int MAX_DEPTH  = 64;
	localparam int MATE_LIMIT = MATE_VALUE - MAX_DEPTH;

	// score plus or minus ply fits in 18 signed bits
	localparam int SCORE_X_W = 18;
	localparam logic signed [SCORE_X_W-1:0] MATE_LIM_X = SCORE_X_W'(MATE_LIMIT);

	localparam logic CMD_PROBE = 1'b0;
	localparam logic CMD_STORE = 1'b1;

	localparam logic [1:0] BOUND_EXACT = 2'd0;
	localparam logic [1:0] BOUND_UPPER = 2'd1;
	localparam logic [1:0] BOUND_LOWER = 2'd2;

	typedef struct packed {
		logic               command;
		logic [63:0]        position_key;
		logic [6:0]         search_depth;
		logic [9:0]         ply_count;
		logic signed [15:0] alpha_bound;
		logic signed [15:0] beta_bound;
		logic signed [15:0] store_score;
		logic [1:0]         bound_kind;
		logic [15:0]        new_move;
	} req_t;

	typedef struct packed {
		logic               key_match;
		logic               cutoff;
		logic signed [15:0] cut_score;
		logic [15:0]        found_move;
		logic               written;
	} rsp_t;

	typedef struct packed {
		logic [63:0]        key;
		logic signed [15:0] score;
		logic [6:0]         depth;
		logic [1:0]         kind;
		logic [15:0]        move;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;    // write one cleared slot, advance sweep counter
		logic capture;  // latch the request
		logic read;     // read the addressed slot
		logic commit;   // write back (store) and load the result register
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
	} dp_sts_t;

	function automatic logic signed [15:0] sat16(input logic signed [SCORE_X_W-1:0] v);
		if (v > 18'sd32767)
			return 16'sh7fff;
		else if (v < -18'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

endpackage

>>> hdl/ttps_ctrl.sv
// ----------------------------------------------------------------------------
// ttps_ctrl
// Sequencer: clearing sweep, then accept / read / evaluate per item.
// ----------------------------------------------------------------------------
module ttps_ctrl import ttps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output ctl_cmd_t cmd,
	input  dp_sts_t  sts
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_EXEC  = 2'd3;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;
	logic       commit;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;

	// result register is free or emptying this cycle
	assign commit = (state_q == ST_EXEC) && (!out_valid_q || !rsp_stall);

	always_comb begin
		cmd.clear   = (state_q == ST_CLEAR);
		cmd.capture = (state_q == ST_IDLE) && req_valid;
		cmd.read    = (state_q == ST_READ);
		cmd.commit  = commit;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid)
					state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (commit)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit)
				out_valid_q <= 1'b1;
			else if (!rsp_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> hdl/ttps_dpath.sv
// ----------------------------------------------------------------------------
// ttps_dpath
// Slot memory, request register, probe/store evaluation, result register.
// ----------------------------------------------------------------------------
module ttps_dpath import ttps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ctl_cmd_t cmd,
	output dp_sts_t  sts,
	input  req_t     req_data,
	output rsp_t     rsp_data
);

	entry_t mem [ENTRIES];

	req_t             req_q;
	entry_t           ent_q;
	rsp_t             rsp_q;
	logic [IDX_W-1:0] clr_cnt_q;

	logic [IDX_W-1:0]           idx;
	logic                       hit;
	logic                       deep;
	logic                       wr_ok;
	logic signed [SCORE_X_W-1:0] ply_x;
	logic signed [SCORE_X_W-1:0] st_x;
	logic signed [SCORE_X_W-1:0] got_x;
	logic signed [SCORE_X_W-1:0] new_x;
	logic signed [SCORE_X_W-1:0] alpha_x;
	logic signed [SCORE_X_W-1:0] beta_x;
	logic signed [SCORE_X_W-1:0] put_x;
	logic                       cut;
	logic signed [15:0]         cut_val;
	rsp_t                       rsp_d;
	entry_t                     wr_ent;
	logic                       wr_en;
	logic [IDX_W-1:0]           wr_addr;

	assign idx = req_q.position_key[IDX_W-1:0];
	assign sts.clr_last = (clr_cnt_q == IDX_W'(ENTRIES - 1));

	always_comb begin
		ply_x   = SCORE_X_W'(req_q.ply_count);
		st_x    = SCORE_X_W'(ent_q.score);
		new_x   = SCORE_X_W'(req_q.store_score);
		alpha_x = SCORE_X_W'(req_q.alpha_bound);
		beta_x  = SCORE_X_W'(req_q.beta_bound);

		hit   = (ent_q.key == req_q.position_key);
		deep  = (ent_q.depth >= req_q.search_depth);
		wr_ok = (ent_q.key == '0) || hit || (req_q.search_depth >= ent_q.depth);

		// mate scores: stored form is relative, returned form is ply adjusted
		if (st_x > MATE_LIM_X)
			got_x = st_x - ply_x;
		else if (st_x < -MATE_LIM_X)
			got_x = st_x + ply_x;
		else
			got_x = st_x;

		if (new_x > MATE_LIM_X)
			put_x = new_x + ply_x;
		else if (new_x < -MATE_LIM_X)
			put_x = new_x - ply_x;
		else
			put_x = new_x;

		cut     = 1'b0;
		cut_val = '0;
		case (ent_q.kind)
			BOUND_EXACT: begin
				cut     = 1'b1;
				cut_val = sat16(got_x);
			end
			BOUND_LOWER: begin
				if (got_x >= beta_x) begin
					cut     = 1'b1;
					cut_val = req_q.beta_bound;
				end
			end
			BOUND_UPPER: begin
				if (got_x <= alpha_x) begin
					cut     = 1'b1;
					cut_val = req_q.alpha_bound;
				end
			end
			default: begin
				cut = 1'b0;
			end
		endcase

		rsp_d = '0;
		if (req_q.command == CMD_PROBE) begin
			rsp_d.key_match  = hit;
			rsp_d.found_move = hit ? ent_q.move : 16'd0;
			if (hit && deep && cut) begin
				rsp_d.cutoff    = 1'b1;
				rsp_d.cut_score = cut_val;
			end
		end else begin
			rsp_d.written = wr_ok;
		end

		wr_ent.key   = req_q.position_key;
		wr_ent.score = sat16(put_x);
		wr_ent.depth = req_q.search_depth;
		wr_ent.kind  = req_q.bound_kind;
		wr_ent.move  = req_q.new_move;

		wr_en   = cmd.clear || (cmd.commit && (req_q.command == CMD_STORE) && wr_ok);
		wr_addr = cmd.clear ? clr_cnt_q : idx;
	end

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= cmd.clear ? entry_t'('0) : wr_ent;
		if (cmd.read)
			ent_q <= mem[idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			req_q <= req_data;
		if (cmd.commit)
			rsp_q <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (cmd.clear)
			clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	assign rsp_data = rsp_q;

endmodule

>>> hdl/transposition_table_probe_store_top.sv
// ----------------------------------------------------------------------------
// transposition_table_probe_store_top
// Direct-mapped transposition table with depth-preferred replacement.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+---------------------------
//  request | req_valid / req_stall  | req_data  (probe or store)
//  result  | rsp_valid / rsp_stall  | rsp_data  (one per request)
//
// Each request passes through capture, slot read, then evaluate and write back;
// the slot read is registered ahead of the write back.
// After reset a clearing pass writes all 4096 slots, one per cycle; req_stall
// stays high until that pass is done.
// While a result waits under rsp_stall, the next request is still taken and
// parks in its evaluate cycle until the result register frees up.
// ----------------------------------------------------------------------------
module transposition_table_probe_store_top import ttps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_data
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	ttps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	ttps_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req_data (req_data),
		.rsp_data (rsp_data)
	);

endmodule

>>> hdl/ttps_checker.sv
// ----------------------------------------------------------------------------
// ttps_checker
// Port-level checks for the transposition table block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttps_checker import ttps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req_data,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp_data
);

	logic req_xfer;
	assign req_xfer = req_valid && !req_stall;

	// a held result keeps its value
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

	// one request in flight: a transfer is never followed directly by another
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_xfer, req_stall)

	// store results carry only the written flag
	`ASSERT_NOW(a_store_clean, clk, arst_n, rsp_valid && rsp_data.written, !rsp_data.key_match && !rsp_data.cutoff && (rsp_data.cut_score == 16'sd0) && (rsp_data.found_move == 16'd0))

	// a cutoff needs a key match
	`ASSERT_NOW(a_cut_hit, clk, arst_n, rsp_valid && rsp_data.cutoff, rsp_data.key_match)

	// no cutoff, no score
	`ASSERT_NOW(a_nocut_zero, clk, arst_n, rsp_valid && !rsp_data.cutoff, rsp_data.cut_score == 16'sd0)

endmodule

bind transposition_table_probe_store_top ttps_checker u_ttps_checker (.*);

>>> tb/transposition_table_probe_store_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// transposition_table_probe_store_top_test
// Drives probe and store transfers into the transposition table and checks
// each result against a scripted want or a table model kept in step with the
// block. A short scripted run covers empty slots, replacement, mate shifts and
// saturation; random traffic over a small pool of colliding keys follows.
// ----------------------------------------------------------------------------
module transposition_table_probe_store_top_test;
	import ttps_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int RANDOM_ITEMS = 650;
	localparam int TAIL_CYCLES  = 10;

	localparam logic [1:0] BOUND_UNUSED = 2'd3;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	typedef struct {
		req_t req;
		bit   typed;
		rsp_t want;
	} script_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data  = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;

	entry_t      tt_slots [ENTRIES];
	rsp_t        results_due [$];
	script_row_t script [$];
	logic [63:0] key_pool [16];
	int          mismatches  = 0;
	int          cycle_count = 0;
	int          burst_left  = 0;
	int          stall_run   = 0;
	stall_mode_t stall_mode  = STALL_NONE;

	transposition_table_probe_store_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [15:0] clamp16(input int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return 16'(v);
	endfunction

	// table model: returns the result of one transfer and updates the slots
	function automatic rsp_t tt_access(input req_t r);
		rsp_t   res;
		entry_t e;
		int     slot;
		int     s;
		int     lim;
		int     ply;
		res  = '0;
		slot = int'(r.position_key % 64'(ENTRIES));
		e    = tt_slots[slot];
		lim  = MATE_VALUE - MAX_DEPTH;
		ply  = int'(r.ply_count);
		if (r.command == CMD_PROBE) begin
			if (e.key != r.position_key)
				return res;
			res.key_match  = 1'b1;
			res.found_move = e.move;
			if (e.depth < r.search_depth)
				return res;
			s = int'(e.score);
			if (s > lim)
				s -= ply;
			else if (s < -lim)
				s += ply;
			case (e.kind)
			BOUND_EXACT: begin
				res.cutoff    = 1'b1;
				res.cut_score = clamp16(s);
			end
			BOUND_LOWER: begin
				if (s >= int'(r.beta_bound)) begin
					res.cutoff    = 1'b1;
					res.cut_score = r.beta_bound;
				end
			end
			BOUND_UPPER: begin
				if (s <= int'(r.alpha_bound)) begin
					res.cutoff    = 1'b1;
					res.cut_score = r.alpha_bound;
				end
			end
			default: ;
			endcase
		end else if (e.key == '0 || e.key == r.position_key || r.search_depth >= e.depth) begin
			s = int'(r.store_score);
			if (s > lim)
				s += ply;
			else if (s < -lim)
				s -= ply;
			e.key          = r.position_key;
			e.score        = clamp16(s);
			e.depth        = r.search_depth;
			e.kind         = r.bound_kind;
			e.move         = r.new_move;
			tt_slots[slot] = e;
			res.written    = 1'b1;
		end
		return res;
	endfunction

	function automatic req_t probe_req(input logic [63:0] key, input int depth, input int ply,
			input int alpha, input int beta);
		req_t r;
		r              = '0;
		r.command      = CMD_PROBE;
		r.position_key = key;
		r.search_depth = 7'(depth);
		r.ply_count    = 10'(ply);
		r.alpha_bound  = 16'(alpha);
		r.beta_bound   = 16'(beta);
		return r;
	endfunction

	function automatic req_t store_req(input logic [63:0] key, input int depth, input int ply,
			input int score, input logic [1:0] kind, input logic [15:0] move);
		req_t r;
		r              = '0;
		r.command      = CMD_STORE;
		r.position_key = key;
		r.search_depth = 7'(depth);
		r.ply_count    = 10'(ply);
		r.store_score  = 16'(score);
		r.bound_kind   = kind;
		r.new_move     = move;
		return r;
	endfunction

	// mate-range, near-zero or full-width scores so bound compares go both ways
	function automatic int random_score();
		int pick;
		int mag;
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			mag = int'($urandom_range(29900, 30000));
			return $urandom_range(0, 1) ? mag : -mag;
		end
		if (pick < 9)
			return int'($urandom_range(0, 400)) - 200;
		return int'($signed(16'($urandom)));
	endfunction

	function automatic req_t random_req();
		req_t r;
		int   pick;
		r.command = $urandom_range(0, 1) ? CMD_STORE : CMD_PROBE;
		pick      = $urandom_range(0, 99);
		if (pick < 80)
			r.position_key = key_pool[$urandom_range(0, 15)];
		else if (pick < 83)
			r.position_key = '0;
		else
			r.position_key = {$urandom, $urandom};
		r.search_depth = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(65, 127))
			: 7'($urandom_range(0, 64));
		r.ply_count    = $urandom_range(0, 1) ? 10'($urandom_range(0, 1023))
			: 10'($urandom_range(0, 8));
		r.alpha_bound  = 16'(random_score());
		r.beta_bound   = 16'(random_score());
		r.store_score  = 16'(random_score());
		r.bound_kind   = ($urandom_range(0, 9) == 0) ? BOUND_UNUSED : 2'($urandom_range(0, 2));
		r.new_move     = 16'($urandom);
		return r;
	endfunction

	task automatic add_row(input req_t r, input bit typed, input rsp_t w);
		script_row_t row;
		row.req   = r;
		row.typed = typed;
		row.want  = w;
		script.push_back(row);
	endtask

	// one request transfer, in bursts with random gaps between them
	task automatic send(input req_t r, input bit typed, input rsp_t w);
		rsp_t predicted;
		int   gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (req_stall);
		predicted = tt_access(r);
		results_due.push_back(typed ? w : predicted);
	endtask

	task automatic drain();
		req_valid  <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (results_due.size() != 0);
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %h got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL transposition_table_probe_store_top");
			$finish;
		end
	end

	// receiver stall pattern, changing mode when each run of random length ends
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_run  <= $urandom_range(16, 80);
		end else begin
			stall_run <= stall_run - 1;
		end
		case (stall_mode)
		STALL_NONE:  rsp_stall <= 1'b0;
		STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
		STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 0);
		default:     rsp_stall <= (stall_run % 7) < 3;
		endcase
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (results_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result transfer, expected none got %h", $time,
					rsp_data);
			end else begin
				want = results_due.pop_front();
				compare_field("key_match", 16'(want.key_match), 16'(rsp_data.key_match));
				compare_field("cutoff", 16'(want.cutoff), 16'(rsp_data.cutoff));
				compare_field("cut_score", want.cut_score, rsp_data.cut_score);
				compare_field("found_move", want.found_move, rsp_data.found_move);
				compare_field("written", 16'(want.written), 16'(rsp_data.written));
			end
		end
	end

	initial begin
		logic [IDX_W-1:0] pool_slot;
		logic [63:0]      k_a;
		logic [63:0]      k_b;
		logic [63:0]      k_c;
		logic [63:0]      k_d;
		logic [63:0]      k_e;
		logic [63:0]      k_f;
		logic [63:0]      k_z;
		logic [63:0]      k_ones;
		rsp_t             none;

		foreach (tt_slots[i])
			tt_slots[i] = '0;
		// pairs of keys sharing a slot, so replacement and misses both occur
		for (int i = 0; i < 16; i++) begin
			if (i % 2 == 0)
				pool_slot = IDX_W'($urandom);
			key_pool[i]            = {$urandom, $urandom};
			key_pool[i][IDX_W-1:0] = pool_slot;
		end

		k_a    = 64'h0123_4567_89ab_c005;
		k_b    = 64'hfedc_ba98_7654_3005;
		k_c    = 64'h8000_0000_0000_0006;
		k_d    = 64'h5555_aaaa_5555_a007;
		k_e    = 64'haaaa_5555_aaaa_5008;
		k_f    = 64'h0000_0000_0000_1009;
		k_z    = 64'h0000_0000_0000_1000;
		k_ones = '1;
		none   = '0;

		// key zero hits an empty slot right after reset
		add_row(probe_req('0, 0, 0, 0, 0), 1'b1, rsp_t'{1'b1, 1'b1, 16'sd0, 16'h0, 1'b0});
		add_row(probe_req(k_a, 0, 0, 0, 0), 1'b1, none);
		add_row(probe_req('0, 1, 0, 0, 0), 1'b1, rsp_t'{1'b1, 1'b0, 16'sd0, 16'h0, 1'b0});
		add_row(store_req(k_a, 10, 0, 100, BOUND_EXACT, 16'hffff), 1'b1,
			rsp_t'{1'b0, 1'b0, 16'sd0, 16'h0, 1'b1});
		add_row(probe_req(k_a, 10, 5, 0, 0), 1'b1,
			rsp_t'{1'b1, 1'b1, 16'sd100, 16'hffff, 1'b0});
		add_row(probe_req(k_a, 11, 5, 0, 0), 1'b1,
			rsp_t'{1'b1, 1'b0, 16'sd0, 16'hffff, 1'b0});
		// other key, shallower: the deeper entry survives
		add_row(store_req(k_b, 5, 0, -50, BOUND_LOWER, 16'h1234), 1'b1, none);
		add_row(store_req(k_b, 10, 0, -50, BOUND_LOWER, 16'h1234), 1'b1,
			rsp_t'{1'b0, 1'b0, 16'sd0, 16'h0, 1'b1});
		add_row(probe_req(k_a, 0, 0, 0, 0), 1'b1, none);
		add_row(probe_req(k_b, 10, 0, 0, -60), 1'b1,
			rsp_t'{1'b1, 1'b1, -16'sd60, 16'h1234, 1'b0});
		add_row(probe_req(k_b, 3, 0, 0, -40), 1'b1,
			rsp_t'{1'b1, 1'b0, 16'sd0, 16'h1234, 1'b0});
		// mate scores shifted by the ply, both ways
		add_row(store_req(k_c, 64, 1023, 30000, BOUND_LOWER, 16'h0001), 1'b0, none);
		add_row(probe_req(k_c, 64, 0, 0, 30000), 1'b0, none);
		add_row(probe_req(k_c, 64, 1023, 0, 29000), 1'b0, none);
		// saturation on store
		add_row(store_req(k_d, 127, 1023, 32767, BOUND_EXACT, 16'h0002), 1'b0, none);
		add_row(probe_req(k_d, 127, 0, 0, 0), 1'b0, none);
		add_row(store_req(k_e, 0, 1023, -32768, BOUND_UPPER, 16'h8000), 1'b0, none);
		add_row(probe_req(k_e, 0, 1, -30000, 0), 1'b0, none);
		add_row(probe_req(k_e, 0, 1, -32768, 32767), 1'b0, none);
		// unused bound kind never cuts off
		add_row(store_req(k_f, 20, 0, 0, BOUND_UNUSED, 16'h0003), 1'b0, none);
		add_row(probe_req(k_f, 0, 0, 32767, -32768), 1'b0, none);
		add_row(store_req(k_ones, 64, 512, -29999, BOUND_EXACT, 16'h0000), 1'b0, none);
		add_row(probe_req(k_ones, 0, 1023, 0, 0), 1'b0, none);
		add_row(store_req(k_z, 30, 0, 5, BOUND_UPPER, 16'h0007), 1'b1,
			rsp_t'{1'b0, 1'b0, 16'sd0, 16'h0, 1'b1});
		add_row(probe_req('0, 0, 0, 0, 0), 1'b1, none);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			send(script[i].req, script[i].typed, script[i].want);
		drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				drain();
			send(random_req(), 1'b0, none);
		end
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("PASS transposition_table_probe_store_top");
		else
			$display("FAIL transposition_table_probe_store_top");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/ttps_pkg.sv
hdl/ttps_ctrl.sv
hdl/ttps_dpath.sv
hdl/transposition_table_probe_store_top.sv
hdl/ttps_checker.sv
tb/transposition_table_probe_store_top_test.sv
